// File: rtl/ordered_list_engine_core_assert.svh
// Assertion macros for the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// Expression must hold at every clock edge outside reset.
`define OLE_ASSERT_HOLDS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// Consequent must hold at the delay n after the antecedent.
`define OLE_ASSERT_AFTER(lbl, clk, rstn, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) else $error(msg);

`endif

// File: rtl/olist_pkg.sv
// Shared types and codes of the ordered list engine.
package olist_pkg;

  localparam int DataW  = 32;
  localparam int IndexW = 4;
  localparam int CountW = 5;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_INSERT_AT  = 3'd4,
    FN_REMOVE_AT  = 3'd5,
    FN_FIND       = 3'd6,
    FN_READ_AT    = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    func_e                     func;
    logic signed [DataW-1:0]   value;
    logic        [IndexW-1:0]  index;
    logic                      clear_all;
  } in_word_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DataW-1:0]   data;
    logic        [IndexW-1:0]  position;
    logic        [CountW-1:0]  count;
  } out_word_t;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [DataW-1:0]   value;
  } chain_cmd_t;

endpackage

// File: rtl/olist_cell.sv
// One storage cell of the list chain, holding the element at a fixed position.
module olist_cell #(
  parameter int PtrW = 4,
  parameter int Pos  = 0
) (
  input  logic                                clk_i,
  input  olist_pkg::chain_cmd_t               cmd_i,
  input  logic [PtrW-1:0]                     pos_i,
  input  logic signed [olist_pkg::DataW-1:0]  lower_i,
  input  logic signed [olist_pkg::DataW-1:0]  upper_i,
  output logic signed [olist_pkg::DataW-1:0]  value_o
);

  localparam logic [PtrW-1:0] Here = PtrW'(Pos);

  logic signed [olist_pkg::DataW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (cmd_i.op)
      olist_pkg::CELL_HOLD: begin
        value_d = value_q;
      end
      olist_pkg::CELL_INSERT: begin
        // open a gap at the insert point, take the new word there
        if (Here > pos_i) begin
          value_d = lower_i;
        end else if (Here == pos_i) begin
          value_d = cmd_i.value;
        end
      end
      olist_pkg::CELL_REMOVE: begin
        if (Here >= pos_i) begin
          value_d = upper_i;
        end
      end
      olist_pkg::CELL_ROTATE: begin
        value_d = upper_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// File: rtl/ordered_list_engine_core.sv
// Top level of the ordered list engine: cell chain and its sequencer.
//
// Usage: request words enter on in_valid_i/in_ready_o/in_word_i, one result word
// per request leaves on out_valid_o/out_ready_i/out_word_o. The list lives in a
// row of DEPTH cells, element k in cell k.
// Clear, push front, push back, pop front, insert at, and any refused request
// are done in the cycle the word is accepted: the result is valid in the next
// cycle; a new word can follow in every cycle while the output register is
// free or draining. Pop back, remove at, find and read at rotate the whole
// chain once round to bring every element past cell 0: a rotation step for
// every cell, then a finishing step that registers the result. No new word
// is taken meanwhile.
// Reset empties the list (count zero); cell contents stay undefined until
// written and are never read beyond the current count.
// A stalled receiver holds the result in the output register; a new request is
// taken only in a cycle where that register is empty or being drained.
module ordered_list_engine_core #(
  parameter int DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  olist_pkg::in_word_t   in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output olist_pkg::out_word_t  out_word_o
);

  `include "ordered_list_engine_core_assert.svh"

  localparam int PtrW   = $clog2(DEPTH);
  localparam int LenW   = $clog2(DEPTH + 1);
  localparam int CmpW   = (LenW > olist_pkg::IndexW) ? LenW : olist_pkg::IndexW;
  localparam int DataW  = olist_pkg::DataW;
  localparam int CountW = olist_pkg::CountW;
  localparam int IndexW = olist_pkg::IndexW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROTATE,
    S_FINISH
  } ctrl_state_e;

  // Sequencer registers
  ctrl_state_e                 state_q, state_d;
  logic [LenW-1:0]             length_q, length_d;
  logic [PtrW-1:0]             rot_q, rot_d;
  olist_pkg::func_e            job_q, job_d;
  logic [PtrW-1:0]             target_q, target_d;
  logic signed [DataW-1:0]     key_q, key_d;
  logic signed [DataW-1:0]     data_q, data_d;
  logic                        found_q, found_d;
  logic [PtrW-1:0]             fpos_q, fpos_d;
  logic                        out_valid_q, out_valid_d;
  olist_pkg::out_word_t        out_word_q, out_word_d;

  // Chain
  logic signed [DataW-1:0]     cell_val [DEPTH];
  logic signed [DataW-1:0]     lower_val [DEPTH];
  logic signed [DataW-1:0]     upper_val [DEPTH];
  olist_pkg::chain_cmd_t       chain_cmd;
  logic [PtrW-1:0]             chain_pos;

  // Decode of the incoming word
  logic                        accept;
  logic                        is_empty;
  logic                        is_full;
  logic                        idx_big;
  logic                        start_rot;
  logic [PtrW-1:0]             rot_target;
  olist_pkg::status_e          imm_status;
  logic signed [DataW-1:0]     imm_data;
  logic [LenW-1:0]             imm_len;
  olist_pkg::cell_op_e         imm_op;
  logic [PtrW-1:0]             imm_pos;

  // Rotation datapath
  logic signed [DataW-1:0]     head;
  logic                        head_match;
  logic                        last_rot;

  // Build the row of cells; the top cell wraps round to cell 0 for rotation
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign lower_val[k] = '0;
    end else begin : g_inner_lo
      assign lower_val[k] = cell_val[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign upper_val[k] = cell_val[0];
    end else begin : g_inner_hi
      assign upper_val[k] = cell_val[k+1];
    end

    olist_cell #(
      .PtrW (PtrW),
      .Pos  (k)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (chain_cmd),
      .pos_i   (chain_pos),
      .lower_i (lower_val[k]),
      .upper_i (upper_val[k]),
      .value_o (cell_val[k])
    );
  end

  // Take a word only when idle and the output register is free this cycle
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign is_empty = (length_q == '0);
  assign is_full  = (length_q == LenW'(DEPTH));
  assign idx_big  = CmpW'(in_word_i.index) >= CmpW'(length_q);

  // Work out the immediate outcome, or decide to rotate
  always_comb begin
    imm_status = olist_pkg::ST_OK;
    imm_data   = '0;
    imm_len    = length_q;
    imm_op     = olist_pkg::CELL_HOLD;
    imm_pos    = '0;
    start_rot  = 1'b0;
    rot_target = '0;
    if (in_word_i.clear_all) begin
      imm_len = '0;
    end else begin
      unique case (in_word_i.func)
        olist_pkg::FN_PUSH_FRONT: begin
          if (is_full) begin
            imm_status = olist_pkg::ST_FULL;
          end else begin
            imm_op  = olist_pkg::CELL_INSERT;
            imm_len = length_q + LenW'(1);
          end
        end
        olist_pkg::FN_PUSH_BACK: begin
          if (is_full) begin
            imm_status = olist_pkg::ST_FULL;
          end else begin
            imm_op  = olist_pkg::CELL_INSERT;
            imm_pos = PtrW'(length_q);
            imm_len = length_q + LenW'(1);
          end
        end
        olist_pkg::FN_POP_FRONT: begin
          if (is_empty) begin
            imm_status = olist_pkg::ST_EMPTY;
          end else begin
            imm_data = cell_val[0];
            imm_op   = olist_pkg::CELL_REMOVE;
            imm_len  = length_q - LenW'(1);
          end
        end
        olist_pkg::FN_POP_BACK: begin
          if (is_empty) begin
            imm_status = olist_pkg::ST_EMPTY;
          end else begin
            start_rot  = 1'b1;
            rot_target = PtrW'(length_q - LenW'(1));
          end
        end
        olist_pkg::FN_INSERT_AT: begin
          if (idx_big) begin
            imm_status = olist_pkg::ST_BAD_INDEX;
          end else if (is_full) begin
            imm_status = olist_pkg::ST_FULL;
          end else begin
            imm_op  = olist_pkg::CELL_INSERT;
            imm_pos = PtrW'(in_word_i.index);
            imm_len = length_q + LenW'(1);
          end
        end
        olist_pkg::FN_REMOVE_AT: begin
          if (is_empty) begin
            imm_status = olist_pkg::ST_EMPTY;
          end else if (idx_big) begin
            imm_status = olist_pkg::ST_BAD_INDEX;
          end else begin
            start_rot  = 1'b1;
            rot_target = PtrW'(in_word_i.index);
          end
        end
        olist_pkg::FN_FIND: begin
          if (is_empty) begin
            imm_status = olist_pkg::ST_EMPTY;
          end else begin
            start_rot = 1'b1;
          end
        end
        olist_pkg::FN_READ_AT: begin
          if (is_empty) begin
            imm_status = olist_pkg::ST_EMPTY;
          end else if (idx_big) begin
            imm_status = olist_pkg::ST_BAD_INDEX;
          end else begin
            start_rot  = 1'b1;
            rot_target = PtrW'(in_word_i.index);
          end
        end
        default: begin
          imm_status = olist_pkg::ST_OK;
        end
      endcase
    end
  end

  // Element rot_q sits in cell 0 during rotation step rot_q
  assign head       = cell_val[0];
  assign head_match = (head == key_q) && (LenW'(rot_q) < length_q);
  assign last_rot   = (rot_q == PtrW'(DEPTH - 1));

  always_comb begin
    state_d       = state_q;
    length_d      = length_q;
    rot_d         = rot_q;
    job_d         = job_q;
    target_d      = target_q;
    key_d         = key_q;
    data_d        = data_q;
    found_d       = found_q;
    fpos_d        = fpos_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_word_d    = out_word_q;
    chain_cmd.op    = olist_pkg::CELL_HOLD;
    chain_cmd.value = in_word_i.value;
    chain_pos       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (start_rot) begin
            // hold the request and spin the chain once round
            state_d  = S_ROTATE;
            rot_d    = '0;
            job_d    = in_word_i.func;
            target_d = rot_target;
            key_d    = in_word_i.value;
            data_d   = '0;
            found_d  = 1'b0;
            fpos_d   = '0;
          end else begin
            chain_cmd.op = imm_op;
            chain_pos    = imm_pos;
            length_d     = imm_len;
            out_valid_d  = 1'b1;
            out_word_d   = '{status:   imm_status,
                             data:     imm_data,
                             position: '0,
                             count:    CountW'(imm_len)};
          end
        end
      end
      S_ROTATE: begin
        chain_cmd.op = olist_pkg::CELL_ROTATE;
        rot_d        = rot_q + PtrW'(1);
        if (rot_q == target_q) begin
          data_d = head;
        end
        if (!found_q && head_match) begin
          found_d = 1'b1;
          fpos_d  = rot_q;
        end
        if (last_rot) begin
          state_d = S_FINISH;
          rot_d   = '0;
        end
      end
      S_FINISH: begin
        // chain is back in order; close the gap where needed and report
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        out_word_d  = '{status:   olist_pkg::ST_OK,
                        data:     data_q,
                        position: '0,
                        count:    CountW'(length_q)};
        unique case (job_q)
          olist_pkg::FN_POP_BACK: begin
            length_d         = length_q - LenW'(1);
            out_word_d.count = CountW'(length_q - LenW'(1));
          end
          olist_pkg::FN_REMOVE_AT: begin
            chain_cmd.op     = olist_pkg::CELL_REMOVE;
            chain_pos        = target_q;
            length_d         = length_q - LenW'(1);
            out_word_d.count = CountW'(length_q - LenW'(1));
          end
          olist_pkg::FN_FIND: begin
            out_word_d.data = '0;
            if (found_q) begin
              out_word_d.position = IndexW'(fpos_q);
            end else begin
              out_word_d.status = olist_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            out_word_d.data = data_q;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      length_q    <= '0;
      rot_q       <= '0;
      job_q       <= olist_pkg::FN_PUSH_FRONT;
      target_q    <= '0;
      key_q       <= '0;
      data_q      <= '0;
      found_q     <= 1'b0;
      fpos_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      length_q    <= length_d;
      rot_q       <= rot_d;
      job_q       <= job_d;
      target_q    <= target_d;
      key_q       <= key_d;
      data_q      <= data_d;
      found_q     <= found_d;
      fpos_q      <= fpos_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Checks on the sequencer
  `OLE_ASSERT_HOLDS(a_len_bound, clk_i, rst_ni, length_q <= LenW'(DEPTH), "length beyond depth")
  `OLE_ASSERT_HOLDS(a_rot_idle, clk_i, rst_ni, (state_q != S_IDLE) || (rot_q == '0), "rotation counter not parked")
  `OLE_ASSERT_NEXT(a_finish, clk_i, rst_ni, state_q == S_FINISH, (state_q == S_IDLE) && out_valid_o, "finish did not report")
  `OLE_ASSERT_AFTER(a_rot_latency, clk_i, rst_ni, accept && start_rot, (DEPTH + 2), out_valid_o, "rotating request late")

endmodule

// File: tb/tb_ordered_list_engine_core.sv
// Self-checking testbench for the ordered list engine core, with its own list predictor.
module tb_ordered_list_engine_core;

  localparam int DEPTH       = 16;
  localparam int IDLE_PCT    = 13;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_REPORTS = 50;
  localparam int DataW       = olist_pkg::DataW;
  localparam int IndexW      = olist_pkg::IndexW;
  localparam int CountW      = olist_pkg::CountW;

  localparam logic signed [DataW-1:0] MIN_VALUE = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] MAX_VALUE = 32'sh7fff_ffff;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_ANY
  } mix_e;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  olist_pkg::in_word_t  req_word  = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  olist_pkg::out_word_t res_word;

  // predicted list contents and length
  logic signed [DataW-1:0] list_mem [DEPTH];
  int                      list_len = 0;

  olist_pkg::out_word_t    pending_results [$];
  logic signed [DataW-1:0] value_pool [8];
  int                      mismatch_count = 0;
  int                      cycle_count = 0;
  bit                      quiet = 1'b0;

  ordered_list_engine_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_word_i  (req_word),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_word_o (res_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  // Apply one request to the predicted list and return the result it should give.
  function automatic olist_pkg::out_word_t apply_request(input olist_pkg::in_word_t w);
    olist_pkg::out_word_t r;
    int                   k;
    r = '0;
    r.status = olist_pkg::ST_OK;
    if (w.clear_all) begin
      list_len = 0;
    end else begin
      case (w.func)
        olist_pkg::FN_PUSH_FRONT, olist_pkg::FN_PUSH_BACK: begin
          if (list_len >= DEPTH) begin
            r.status = olist_pkg::ST_FULL;
          end else if (w.func == olist_pkg::FN_PUSH_BACK) begin
            list_mem[list_len] = w.value;
            list_len++;
          end else begin
            for (k = list_len; k > 0; k--) list_mem[k] = list_mem[k-1];
            list_mem[0] = w.value;
            list_len++;
          end
        end
        olist_pkg::FN_POP_FRONT: begin
          if (list_len == 0) begin
            r.status = olist_pkg::ST_EMPTY;
          end else begin
            r.data = list_mem[0];
            for (k = 0; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
            list_len--;
          end
        end
        olist_pkg::FN_POP_BACK: begin
          if (list_len == 0) begin
            r.status = olist_pkg::ST_EMPTY;
          end else begin
            r.data = list_mem[list_len-1];
            list_len--;
          end
        end
        olist_pkg::FN_INSERT_AT: begin
          if (int'(w.index) >= list_len) begin
            r.status = olist_pkg::ST_BAD_INDEX;
          end else if (list_len >= DEPTH) begin
            r.status = olist_pkg::ST_FULL;
          end else begin
            for (k = list_len; k > int'(w.index); k--) list_mem[k] = list_mem[k-1];
            list_mem[w.index] = w.value;
            list_len++;
          end
        end
        olist_pkg::FN_REMOVE_AT: begin
          if (list_len == 0) begin
            r.status = olist_pkg::ST_EMPTY;
          end else if (int'(w.index) >= list_len) begin
            r.status = olist_pkg::ST_BAD_INDEX;
          end else begin
            r.data = list_mem[w.index];
            for (k = int'(w.index); k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
            list_len--;
          end
        end
        olist_pkg::FN_FIND: begin
          if (list_len == 0) begin
            r.status = olist_pkg::ST_EMPTY;
          end else begin
            r.status = olist_pkg::ST_NOT_FOUND;
            for (k = 0; k < list_len; k++) begin
              if (list_mem[k] == w.value) begin
                r.status   = olist_pkg::ST_OK;
                r.position = k[IndexW-1:0];
                break;
              end
            end
          end
        end
        default: begin
          if (list_len == 0) begin
            r.status = olist_pkg::ST_EMPTY;
          end else if (int'(w.index) >= list_len) begin
            r.status = olist_pkg::ST_BAD_INDEX;
          end else begin
            r.data = list_mem[w.index];
          end
        end
      endcase
    end
    r.count = list_len[CountW-1:0];
    return r;
  endfunction

  function automatic olist_pkg::in_word_t make_request(input olist_pkg::func_e f,
                                                       input logic signed [DataW-1:0] v,
                                                       input int idx, input bit clr);
    olist_pkg::in_word_t w;
    w.func      = f;
    w.value     = v;
    w.index     = idx[IndexW-1:0];
    w.clear_all = clr;
    return w;
  endfunction

  // Offer one word, hold it until taken, and log its expected result.
  // Called and returns at a falling edge; valid stays high on return.
  task automatic send_word(input olist_pkg::in_word_t w);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk_i);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk_i); while (!req_ready);
    pending_results.push_back(apply_request(w));
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    res_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin : check_result
    olist_pkg::out_word_t want;
    if (rst_ni && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        want = pending_results.pop_front();
        if (res_word.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", res_word.status, want.status));
        if (res_word.data !== want.data)
          report_mismatch($sformatf("data got %0d want %0d", res_word.data, want.data));
        if (res_word.position !== want.position)
          report_mismatch($sformatf("position got %0d want %0d",
                                    res_word.position, want.position));
        if (res_word.count !== want.count)
          report_mismatch($sformatf("count got %0d want %0d", res_word.count, want.count));
      end
    end
  end

  // Every operation but the two pushes against an empty list, clear included.
  task automatic test_empty_list();
    send_word(make_request(olist_pkg::FN_READ_AT, MAX_VALUE, 15, 1'b1));
    send_word(make_request(olist_pkg::FN_POP_FRONT, 0, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_POP_BACK, 0, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_REMOVE_AT, 0, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_READ_AT, 0, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_FIND, 0, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_INSERT_AT, 5, 0, 1'b0));
  endtask

  // Short list with extreme values: indexed edges, find hit and miss, removal of the tail.
  task automatic test_short_list();
    send_word(make_request(olist_pkg::FN_PUSH_BACK, MIN_VALUE, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_PUSH_FRONT, MAX_VALUE, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_INSERT_AT, -1, 1, 1'b0));
    send_word(make_request(olist_pkg::FN_INSERT_AT, 7, 3, 1'b0));
    send_word(make_request(olist_pkg::FN_FIND, -1, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_FIND, 0, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_READ_AT, 0, 2, 1'b0));
    send_word(make_request(olist_pkg::FN_READ_AT, 0, 15, 1'b0));
    send_word(make_request(olist_pkg::FN_REMOVE_AT, 0, 2, 1'b0));
    send_word(make_request(olist_pkg::FN_REMOVE_AT, 0, 2, 1'b0));
    send_word(make_request(olist_pkg::FN_POP_FRONT, 0, 0, 1'b0));
    send_word(make_request(olist_pkg::FN_POP_BACK, 0, 0, 1'b0));
  endtask

  function automatic olist_pkg::in_word_t random_request(input mix_e mix);
    olist_pkg::in_word_t w;
    int                  roll;
    w.func      = olist_pkg::func_e'($urandom_range(7));
    w.value     = $urandom;
    w.index     = IndexW'($urandom_range(15));
    w.clear_all = ($urandom_range(99) < 2);
    roll = $urandom_range(99);
    if (mix == MIX_GROW && roll < 75) begin
      case ($urandom_range(2))
        0:       w.func = olist_pkg::FN_PUSH_FRONT;
        1:       w.func = olist_pkg::FN_PUSH_BACK;
        default: w.func = olist_pkg::FN_INSERT_AT;
      endcase
    end else if (mix == MIX_SHRINK && roll < 70) begin
      case ($urandom_range(2))
        0:       w.func = olist_pkg::FN_POP_FRONT;
        1:       w.func = olist_pkg::FN_POP_BACK;
        default: w.func = olist_pkg::FN_REMOVE_AT;
      endcase
    end
    // reuse a small pool of values so that finds hit
    if ($urandom_range(99) < 40) w.value = value_pool[$urandom_range(7)];
    if (w.func == olist_pkg::FN_FIND && list_len > 0 && $urandom_range(99) < 50)
      w.value = list_mem[$urandom_range(list_len - 1)];
    if (list_len > 0 && $urandom_range(99) < 80)
      w.index = IndexW'($urandom_range(list_len - 1));
    return w;
  endfunction

  // Runs of growing, shrinking and mixed traffic, so the list sweeps empty to full.
  task automatic test_random(input int n_items);
    int   done;
    int   run_len;
    mix_e mix;
    done = 0;
    value_pool[0] = 0;
    value_pool[1] = -1;
    value_pool[2] = MIN_VALUE;
    value_pool[3] = MAX_VALUE;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    while (done < n_items) begin
      mix = mix_e'($urandom_range(2));
      run_len = $urandom_range(10, 40);
      repeat (run_len) begin
        quiet = (done >= 250 && done < 400);
        send_word(random_request(mix));
        done++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_short_list();
    test_random(600);

    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
